[rtl/temperature_to_lcd_writer_defines.svh]
// Assertion macros for the LCD readout RTL; included by tlw_datapath.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef TEMPERATURE_TO_LCD_WRITER_DEFINES_SVH
`define TEMPERATURE_TO_LCD_WRITER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TLW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TLW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tlw_pkg.sv]
// Shared constants, types and the digit table for the LCD readout block.
// No dependencies.
`default_nettype none

package tlw_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int MAX_DIGITS      = 5;
    localparam int NDIG_W          = $clog2(MAX_DIGITS + 1);
    localparam int WIDX_W          = $clog2(MAX_DIGITS + 2);

    localparam logic [7:0]  LINE_TWO_CMD = 8'hC0;
    localparam logic [7:0]  NIBBLE_MASK  = 8'hF0;
    localparam logic [7:0]  SPACE_CHAR   = 8'h20;

    // x/10 == (x * 52429) >> 19 for x below 43698
    localparam logic [15:0] RECIP_10  = 16'd52429;
    localparam int          DIV_SHIFT = 19;

    localparam logic [0:0]  REG_FOUR_BIT_BUS = 1'b0;
    localparam logic        RS_INSTR = 1'b0;
    localparam logic        RS_DATA  = 1'b1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
        logic emit_last;
    } t_status;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        case (d)
            4'd0:    c = "0";
            4'd1:    c = "1";
            4'd2:    c = "2";
            4'd3:    c = "3";
            4'd4:    c = "4";
            4'd5:    c = "5";
            4'd6:    c = "6";
            4'd7:    c = "7";
            4'd8:    c = "8";
            4'd9:    c = "9";
            default: c = SPACE_CHAR;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/tlw_if.sv]
// Valid/ready channel interfaces: converter samples in, LCD bus transfers out.
// Depends on tlw_pkg.
`default_nettype none

interface tlw_sample_if #(parameter int SAMPLE_BITS = tlw_pkg::SAMPLE_BITS_DEF);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface tlw_xfer_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [7:0] bus_value;
    logic       last;

    modport source (output valid, output reg_select, output bus_value, output last,
                    input ready);
    modport sink   (input valid, input reg_select, input bus_value, input last,
                    output ready);
endinterface

`default_nettype wire

[rtl/temperature_to_lcd_writer.sv]
// After a sample is taken, conversion makes one decimal digit per cycle (1..3 for 10-bit
//   samples, 5 at most), then transfers leave one per cycle while the receiver is ready:
//   2 + digits writes, doubled on a 4-bit bus.
// Samples are taken one at a time: a new one waits until the last one's transfers are
//   issued, as the divide-by-ten step and the single output register are shared.
// Reset (i_rst_n, synchronous, active low): sequencer idle, output empty, 8-bit bus.
`default_nettype none

module temperature_to_lcd_writer #(
    parameter int SAMPLE_BITS = tlw_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    tlw_sample_if.sink      i_sample,
    tlw_xfer_if.source      o_xfer,
    input  wire logic       psel,
    input  wire logic       penable,
    input  wire logic       pwrite,
    input  wire logic [2:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic             r_four_bit;
    tlw_pkg::t_cmd    w_cmd;
    tlw_pkg::t_status w_status;
    logic             w_reg_hit;

    // register index is paddr / 4
    assign w_reg_hit = (paddr[2:2] == tlw_pkg::REG_FOUR_BIT_BUS);
    assign pready    = 1'b1;
    assign prdata    = w_reg_hit ? {31'b0, r_four_bit} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_bit <= 1'b0;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_four_bit <= pwdata[0];
        end
    end

    tlw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (i_sample.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tlw_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (i_sample.adc_sample),
        .i_four_bit   (r_four_bit),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_valid      (o_xfer.valid),
        .i_ready      (o_xfer.ready),
        .o_reg_select (o_xfer.reg_select),
        .o_bus_value  (o_xfer.bus_value),
        .o_last       (o_xfer.last)
    );

endmodule

`default_nettype wire

[rtl/tlw_ctrl.sv]
// Sequencer for the readout: accept, digit conversion loop, transfer emission.
// Depends on tlw_pkg.
`default_nettype none

module tlw_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire tlw_pkg::t_status i_status,
    output tlw_pkg::t_cmd        o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd.load     = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.emit     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
                if (i_status.out_free && i_status.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/tlw_datapath.sv]
// Datapath: degree register, divide-by-ten step, digit store, transfer
// formatting and the output register. Depends on tlw_pkg and the macro header.
`default_nettype none
`include "temperature_to_lcd_writer_defines.svh"

module tlw_datapath #(
    parameter int SAMPLE_BITS = tlw_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_four_bit,
    input  wire tlw_pkg::t_cmd          i_cmd,
    output tlw_pkg::t_status            o_status,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic                        o_reg_select,
    output logic [7:0]                  o_bus_value,
    output logic                        o_last
);

    localparam int DEG_W  = SAMPLE_BITS - 1;
    localparam int NDIG_W = tlw_pkg::NDIG_W;
    localparam int WIDX_W = tlw_pkg::WIDX_W;
    localparam logic [NDIG_W-1:0] DIG_LIMIT = NDIG_W'(tlw_pkg::MAX_DIGITS);

    logic [DEG_W-1:0]  r_value;
    logic [NDIG_W-1:0] r_ndig;
    logic [3:0]        r_digits [tlw_pkg::MAX_DIGITS];
    logic [WIDX_W-1:0] r_widx;
    logic              r_half;
    logic              r_out_valid;
    logic              r_out_rs;
    logic [7:0]        r_out_bus;
    logic              r_out_last;

    // one divide-by-ten step
    logic [DEG_W+15:0] w_prod;
    logic [DEG_W-1:0]  w_q;
    logic [DEG_W+3:0]  w_q10;
    logic [3:0]        w_rem;

    assign w_prod = (DEG_W+16)'(r_value) * (DEG_W+16)'(tlw_pkg::RECIP_10);
    assign w_q    = DEG_W'(w_prod >> tlw_pkg::DIV_SHIFT);
    assign w_q10  = ({4'b0, w_q} << 3) + ({4'b0, w_q} << 1);
    assign w_rem  = 4'({4'b0, r_value} - w_q10);

    // write index: 0 = cursor command, 1..ndig = digits MS first, ndig+1 = space
    logic [WIDX_W-1:0] w_space_idx;
    logic [NDIG_W-1:0] w_dig_sel;
    logic [7:0]        w_byte;
    logic              w_rs;
    logic [7:0]        w_xfer;
    logic              w_final;

    assign w_space_idx = WIDX_W'(r_ndig) + WIDX_W'(1);
    assign w_dig_sel   = r_ndig - NDIG_W'(r_widx);

    always_comb begin
        if (r_widx == '0) begin
            w_rs   = tlw_pkg::RS_INSTR;
            w_byte = tlw_pkg::LINE_TWO_CMD;
        end else if (r_widx == w_space_idx) begin
            w_rs   = tlw_pkg::RS_DATA;
            w_byte = tlw_pkg::SPACE_CHAR;
        end else begin
            w_rs   = tlw_pkg::RS_DATA;
            w_byte = tlw_pkg::digit_char(r_digits[w_dig_sel]);
        end
        if (!i_four_bit) begin
            w_xfer = w_byte;
        end else if (!r_half) begin
            w_xfer = w_byte & tlw_pkg::NIBBLE_MASK;
        end else begin
            w_xfer = {w_byte[3:0], 4'h0};
        end
    end

    assign w_final = (r_widx == w_space_idx) && (!i_four_bit || r_half);

    assign o_status.div_done  = (w_q == '0) ||
                                (r_ndig == NDIG_W'(tlw_pkg::MAX_DIGITS - 1));
    assign o_status.out_free  = !r_out_valid || i_ready;
    assign o_status.emit_last = w_final;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_sample[SAMPLE_BITS-1:1];
            r_ndig  <= '0;
            r_widx  <= '0;
            r_half  <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_digits[r_ndig[NDIG_W-1:0]] <= w_rem;
            r_value <= w_q;
            r_ndig  <= r_ndig + NDIG_W'(1);
        end else if (i_cmd.emit) begin
            if (i_four_bit && !r_half) begin
                r_half <= 1'b1;
            end else begin
                r_half <= 1'b0;
                r_widx <= r_widx + WIDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_rs   <= w_rs;
            r_out_bus  <= w_xfer;
            r_out_last <= w_final;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_reg_select = r_out_rs;
    assign o_bus_value  = r_out_bus;
    assign o_last       = r_out_last;

    `TLW_ASSERT_IMP(a_emit_into_free, i_cmd.emit, !r_out_valid || i_ready, "output overrun")
    `TLW_ASSERT_IMP(a_cmd_exclusive, i_cmd.load, !i_cmd.emit && !i_cmd.div_step, "cmd overlap")
    `TLW_ASSERT_NXT(a_load_clears, i_cmd.load, r_ndig == '0 && r_widx == '0, "count not cleared")
    `TLW_ASSERT_IMP(a_digit_bound, i_cmd.div_step, r_ndig < DIG_LIMIT, "too many digits")

endmodule

`default_nettype wire

[tb/tlw_readout_check.sv]
// Scoreboard for the LCD readout block: predicts the bus transfers of each sample.
// Watches the sample and transfer channels and the APB port; depends on tlw_pkg, tlw_if.
`timescale 1ns / 1ps

module tlw_readout_check (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tlw_sample_if            i_sample,
    tlw_xfer_if              i_xfer,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               o_errors,
    output int               o_pending
);

    localparam int         SBITS      = tlw_pkg::SAMPLE_BITS_DEF;
    localparam int         MAX_DIG    = tlw_pkg::MAX_DIGITS;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam int         RADIX      = 10;
    localparam int         MAX_WRITES = MAX_DIG + 2;

    typedef struct packed {
        logic       rs;
        logic [7:0] bus;
        logic       last;
    } t_lcd_xfer;

    t_lcd_xfer lcd_writes_due [$];
    logic      nibble_bus = 1'b0;
    int        n_errors   = 0;

    // Cursor command, digits MSD first, trailing space; split into nibbles on a 4-bit bus.
    function automatic void predict_lcd_writes(input logic [SBITS-1:0] sample);
        logic [SBITS-1:0] degrees;
        logic [7:0] chars   [MAX_DIG];
        logic [7:0] wr_byte [MAX_WRITES];
        logic       wr_rs   [MAX_WRITES];
        t_lcd_xfer  xfers   [2*MAX_WRITES];
        int         ndig;
        int         nwr;
        int         n;
        degrees = sample >> 1;
        ndig = 0;
        do begin
            chars[ndig] = ASCII_ZERO + 8'(degrees % RADIX);
            degrees = degrees / RADIX;
            ndig++;
        end while (degrees != 0 && ndig < MAX_DIG);

        wr_byte[0] = tlw_pkg::LINE_TWO_CMD;
        wr_rs[0]   = tlw_pkg::RS_INSTR;
        nwr = 1;
        for (int d = ndig - 1; d >= 0; d--) begin
            wr_byte[nwr] = chars[d];
            wr_rs[nwr]   = tlw_pkg::RS_DATA;
            nwr++;
        end
        wr_byte[nwr] = tlw_pkg::SPACE_CHAR;
        wr_rs[nwr]   = tlw_pkg::RS_DATA;
        nwr++;

        n = 0;
        for (int w = 0; w < nwr; w++) begin
            if (nibble_bus) begin
                xfers[n]     = '{wr_rs[w], wr_byte[w] & tlw_pkg::NIBBLE_MASK, 1'b0};
                xfers[n + 1] = '{wr_rs[w], 8'(wr_byte[w] << 4) & tlw_pkg::NIBBLE_MASK,
                                 1'b0};
                n += 2;
            end else begin
                xfers[n] = '{wr_rs[w], wr_byte[w], 1'b0};
                n++;
            end
        end
        xfers[n - 1].last = 1'b1;
        for (int k = 0; k < n; k++)
            lcd_writes_due.push_back(xfers[k]);
    endfunction

    always @(posedge i_clk) begin
        t_lcd_xfer got;
        t_lcd_xfer want;
        if (!i_rst_n) begin
            nibble_bus = 1'b0;
            lcd_writes_due.delete();
        end else begin
            if (psel && penable && pwrite && pready &&
                paddr[2:2] == tlw_pkg::REG_FOUR_BIT_BUS)
                nibble_bus = pwdata[0];

            // retire before predicting: a sample taken now cannot have a transfer out yet
            if (i_xfer.valid && i_xfer.ready) begin
                got = '{i_xfer.reg_select, i_xfer.bus_value, i_xfer.last};
                if (lcd_writes_due.size() == 0) begin
                    $error("unexpected transfer: reg_select %0d bus_value 0x%02h last %0d",
                           got.rs, got.bus, got.last);
                    n_errors++;
                end else begin
                    want = lcd_writes_due.pop_front();
                    if (got.rs !== want.rs) begin
                        $error("reg_select: expected %0d, got %0d", want.rs, got.rs);
                        n_errors++;
                    end
                    if (got.bus !== want.bus) begin
                        $error("bus_value: expected 0x%02h, got 0x%02h", want.bus, got.bus);
                        n_errors++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        n_errors++;
                    end
                end
            end

            if (i_sample.valid && i_sample.ready)
                predict_lcd_writes(i_sample.adc_sample);
        end
        o_errors  <= n_errors;
        o_pending <= lcd_writes_due.size();
    end

endmodule

[tb/tb_temperature_to_lcd_writer.sv]
// Top of the LCD readout testbench: clock, reset, sample and APB stimulus, verdict.
// Uses tlw_pkg, tlw_if and the tlw_readout_check scoreboard.
`timescale 1ns / 1ps

module tb_temperature_to_lcd_writer;

    localparam int          SBITS        = tlw_pkg::SAMPLE_BITS_DEF;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 40;
    localparam logic [2:0]  ADDR_BUS_MODE = {tlw_pkg::REG_FOUR_BIT_BUS, 2'b00};
    localparam logic [2:0]  ADDR_UNUSED   = 3'd4;   // index 1: no register there
    localparam logic [31:0] MODE_8BIT     = 32'd0;
    localparam logic [31:0] MODE_4BIT     = 32'd1;
    localparam int          N_CORNERS     = 12;
    localparam logic [SBITS-1:0] CORNERS [N_CORNERS] = '{
        10'd0, 10'd1, 10'd2, 10'd19, 10'd20, 10'd199,
        10'd200, 10'd512, 10'd341, 10'd682, 10'd1022, 10'd1023
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          n_errors;
    int          n_pending;
    bit          quiet    = 1'b0;
    bit          hold_req = 1'b0;

    tlw_sample_if #(.SAMPLE_BITS(SBITS)) smp ();
    tlw_xfer_if xfr ();

    temperature_to_lcd_writer #(.SAMPLE_BITS(SBITS)) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp),
        .o_xfer   (xfr),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tlw_readout_check u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sample  (smp),
        .i_xfer    (xfr),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .o_errors  (n_errors),
        .o_pending (n_pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("** temperature_to_lcd_writer: FAILED **");
        $finish;
    end

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic send_sample(input logic [SBITS-1:0] value, input bit may_gap);
        smp.valid      <= 1'b1;
        smp.adc_sample <= value;
        @(posedge i_clk);
        while (!smp.ready) @(posedge i_clk);
        if (may_gap)
            sender_gap();
    endtask

    task automatic wait_drained();
        smp.valid <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [SBITS-1:0] pick_sample();
        // bias toward one- and two-digit readings so every digit count shows up
        case ($urandom_range(0, 3))
            0:       return SBITS'($urandom_range(0, 21));
            1:       return SBITS'($urandom_range(0, 199));
            default: return SBITS'($urandom_range(0, 1023));
        endcase
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            send_sample(pick_sample(), 1'b1);
    endtask

    // Receiver: random ready bursts, one long hold on request.
    initial begin
        forever begin
            if (hold_req) begin
                xfr.ready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                xfr.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                xfr.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        smp.valid      <= 1'b0;
        smp.adc_sample <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner readings on the 8-bit bus out of reset
        for (int i = 0; i < N_CORNERS; i++)
            send_sample(CORNERS[i], 1'b1);
        wait_drained();

        // only bit 0 of the written value counts; the unused index must not disturb it
        write_reg(ADDR_BUS_MODE, 32'hFFFF_FFFF);
        write_reg(ADDR_UNUSED, MODE_8BIT);
        for (int i = 0; i < N_CORNERS; i += 2)
            send_sample(CORNERS[i], 1'b1);
        send_sample(CORNERS[N_CORNERS - 1], 1'b1);
        wait_drained();

        write_reg(ADDR_BUS_MODE, 32'hFFFF_FFFE);
        random_phase(30);
        wait_drained();

        // park the receiver while samples keep coming, so the input backs up
        write_reg(ADDR_BUS_MODE, $urandom());
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++)
            send_sample(pick_sample(), 1'b0);
        random_phase(20);
        wait_drained();

        write_reg(ADDR_BUS_MODE, MODE_4BIT);
        random_phase(40);
        wait_drained();

        write_reg(ADDR_BUS_MODE, MODE_8BIT);
        random_phase(20);
        wait_drained();

        write_reg(ADDR_BUS_MODE, $urandom());
        quiet = 1'b1;
        random_phase(20);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && n_pending == 0)
            $display("** temperature_to_lcd_writer: PASSED **");
        else
            $display("** temperature_to_lcd_writer: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/tlw_pkg.sv
rtl/tlw_if.sv
rtl/tlw_ctrl.sv
rtl/tlw_datapath.sv
rtl/temperature_to_lcd_writer.sv
tb/tlw_readout_check.sv
tb/tb_temperature_to_lcd_writer.sv
